// ----- sv/bol_pkg.sv -----
package bol_pkg;

  localparam int CAPACITY   = 128;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the ports
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 8;
  localparam int POS_W   = 7;
  localparam int LENGTH_W = 8;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LEN_W = $clog2(CAPACITY + 1);

  // match flags are scanned one group of cells per cycle
  localparam int GROUP   = 8;
  localparam int SUB_W   = $clog2(GROUP);
  localparam int NGRP    = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_FIND   = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_INSERT = 3'd4
  } kind_e;

  // command broadcast to every cell
  typedef struct packed {
    logic             wr;
    logic             ins;
    logic             del;
    logic             cmp;
    logic [IDX_W-1:0] pos;
    logic [LEN_W-1:0] len;
    data_t            data;
  } cell_cmd_t;

  function automatic data_t to_data(logic signed [VALUE_W-1:0] v);
    data_t r;
    r = data_t'(v);
    return r;
  endfunction

endpackage

// ----- sv/bol_cell.sv -----
module bol_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bol_pkg::IDX_W-1:0] idx_i,
  input  bol_pkg::cell_cmd_t       cmd_i,
  input  bol_pkg::data_t           left_i,
  input  bol_pkg::data_t           right_i,
  output bol_pkg::data_t           data_o,
  output logic                     match_o
);
  import bol_pkg::*;

  data_t data_q, data_d;
  logic  match_q, match_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.del && (idx_i >= cmd_i.pos)) begin
      data_d = right_i;
    end else if (cmd_i.ins && (idx_i > cmd_i.pos)) begin
      data_d = left_i;
    end else if (cmd_i.wr && (idx_i == cmd_i.pos)) begin
      data_d = cmd_i.data;
    end
  end

  // only cells inside the valid length may flag a match
  always_comb begin
    match_d = match_q;
    if (cmd_i.cmp) begin
      match_d = (data_q == cmd_i.data) && (LEN_W'(idx_i) < cmd_i.len);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ----- sv/bounded_ordered_list.sv -----
// append, clear, insert and unused kinds: result registered in the cycle after the transaction
// find and delete: match flags are latched by all cells at once, then scanned one group
//   of 8 cells per cycle, from the lowest group until a hit or the last group
// delete and insert shift the cells at and above the target position together
// a new request is taken while idle with the result slot free or being drained
// reset clears the length, the control state and the cell match flags; the entry data is not cleared
module bounded_ordered_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bol_pkg::KIND_W-1:0]    kind_i,
  input  logic signed [bol_pkg::VALUE_W-1:0] value_i,
  input  logic [bol_pkg::INDEX_W-1:0]   index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic                          found_o,
  output logic [bol_pkg::POS_W-1:0]     position_o,
  output logic [bol_pkg::LENGTH_W-1:0]  length_o
);
  import bol_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e            state_q;
  logic              is_del_q;
  logic [GRP_W-1:0]  grp_q;
  logic [LEN_W-1:0]  len_q;
  logic              out_valid_q;
  logic              ok_q, found_q;
  logic [POS_W-1:0]  pos_q;
  logic [LENGTH_W-1:0] olen_q;

  cell_cmd_t         cmd;
  data_t             cell_data [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [NGRP*GROUP-1:0] match_pad;
  logic [GROUP-1:0]  grp_bits;
  logic              grp_any;
  logic [SUB_W-1:0]  sub;
  logic [IDX_W-1:0]  hit;
  logic              accept;
  logic              last_grp;
  kind_e             kind;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = kind_e'(kind_i);

  assign match_pad = (NGRP*GROUP)'(match);
  assign grp_bits  = match_pad[GROUP*grp_q +: GROUP];
  assign grp_any   = |grp_bits;
  assign last_grp  = (grp_q == GRP_W'(NGRP - 1));

  // lowest set flag in the current group
  always_comb begin
    sub = '0;
    for (int k = GROUP - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        sub = SUB_W'(k);
      end
    end
  end

  assign hit = IDX_W'({grp_q, sub});

  always_comb begin
    cmd      = '0;
    cmd.len  = len_q;
    cmd.data = to_data(value_i);
    if (accept) begin
      unique case (kind)
        KIND_APPEND: begin
          if (len_q < LEN_W'(CAPACITY)) begin
            cmd.wr  = 1'b1;
            cmd.pos = IDX_W'(len_q);
          end
        end
        KIND_FIND, KIND_DELETE: begin
          cmd.cmp = 1'b1;
        end
        KIND_INSERT: begin
          if ((len_q < LEN_W'(CAPACITY)) && (LEN_W'(index_i) <= len_q)
              && (index_i <= INDEX_W'(len_q))) begin
            cmd.wr  = 1'b1;
            cmd.ins = 1'b1;
            cmd.pos = IDX_W'(index_i);
          end
        end
        default: ;
      endcase
    end else if ((state_q == ST_SCAN) && is_del_q && grp_any) begin
      cmd.del = 1'b1;
      cmd.pos = hit;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    bol_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      is_del_q    <= 1'b0;
      grp_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= 1'b0;
      pos_q       <= '0;
      olen_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ok_q    <= 1'b0;
            found_q <= 1'b0;
            pos_q   <= '0;
            olen_q  <= LENGTH_W'(len_q);
            unique case (kind)
              KIND_APPEND: begin
                out_valid_q <= 1'b1;
                if (cmd.wr) begin
                  len_q  <= len_q + 1'b1;
                  olen_q <= LENGTH_W'(len_q + 1'b1);
                  ok_q   <= 1'b1;
                end
              end
              KIND_INSERT: begin
                out_valid_q <= 1'b1;
                if (cmd.ins) begin
                  len_q  <= len_q + 1'b1;
                  olen_q <= LENGTH_W'(len_q + 1'b1);
                  ok_q   <= 1'b1;
                end
              end
              KIND_CLEAR: begin
                out_valid_q <= 1'b1;
                len_q  <= '0;
                olen_q <= '0;
                ok_q   <= 1'b1;
              end
              KIND_FIND, KIND_DELETE: begin
                state_q  <= ST_SCAN;
                is_del_q <= (kind == KIND_DELETE);
                grp_q    <= '0;
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (grp_any) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            ok_q        <= 1'b1;
            found_q     <= 1'b1;
            pos_q       <= POS_W'(hit);
            if (is_del_q) begin
              len_q  <= len_q - 1'b1;
              olen_q <= LENGTH_W'(len_q - 1'b1);
            end else begin
              olen_q <= LENGTH_W'(len_q);
            end
          end else if (last_grp) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            ok_q        <= 1'b0;
            found_q     <= 1'b0;
            pos_q       <= '0;
            olen_q      <= LENGTH_W'(len_q);
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;
  assign length_o    = olen_q;

endmodule
